@@ hdl/ising_3d_metropolis_update_top_defines.svh @@
// assertion macros for the 3d ising metropolis update block
`ifndef ISING_3D_METROPOLIS_UPDATE_TOP_DEFINES_SVH
`define ISING_3D_METROPOLIS_UPDATE_TOP_DEFINES_SVH

// same-cycle implication, checked outside reset
`define ISG3D_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("same-cycle check failed");

// next-cycle implication, checked outside reset
`define ISG3D_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`endif

@@ hdl/isg3d_pkg.sv @@
// shared types and constants for the 3d ising metropolis update block
`default_nettype none
package isg3d_pkg;

	localparam int SIDE_DEF      = 32;
	localparam int RAND_BITS_DEF = 31;

	localparam int NUM_THRESH = 7;
	localparam int CFG_IDX_W  = 3;
	localparam int THRESH_W   = 31;
	localparam int SITE_W     = 15;
	localparam int DIS_W      = 3;
	localparam int UP_W       = 16;

	typedef logic [THRESH_W-1:0] thresh_t;
	typedef thresh_t [NUM_THRESH-1:0] thresh_arr_t;

	// read slot selector: the site itself, then the six neighbours
	typedef logic [2:0] nbr_sel_t;
	localparam nbr_sel_t NB_SELF = 3'd0;
	localparam nbr_sel_t NB_XP   = 3'd1;
	localparam nbr_sel_t NB_XM   = 3'd2;
	localparam nbr_sel_t NB_YP   = 3'd3;
	localparam nbr_sel_t NB_YM   = 3'd4;
	localparam nbr_sel_t NB_ZP   = 3'd5;
	localparam nbr_sel_t NB_ZM   = 3'd6;

	localparam logic OP_WRITE  = 1'b0;
	localparam logic OP_UPDATE = 1'b1;

	typedef struct packed {
		logic [UP_W-1:0]  up_count;
		logic             spin_out;
		logic [DIS_W-1:0] disagree_count;
		logic             flipped;
	} res_t;

endpackage
`default_nettype wire

@@ hdl/isg3d_ram.sv @@
// generic single-port ram with registered read
`default_nettype none
module isg3d_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 32768
) (
	input  wire logic                     clk,
	input  wire logic                     en,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] addr,
	input  wire logic [WIDTH-1:0]         wdata,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem[addr] <= wdata;
			end else begin
				rdata <= mem[addr];
			end
		end
	end
endmodule
`default_nettype wire

@@ hdl/isg3d_nbr.sv @@
// helical periodic neighbour address generator
`default_nettype none
module isg3d_nbr #(
	parameter int SIDE = 32
) (
	input  wire logic [$clog2(SIDE*SIDE*SIDE)-1:0] site,
	input  wire isg3d_pkg::nbr_sel_t                sel,
	output logic      [$clog2(SIDE*SIDE*SIDE)-1:0] addr
);
	import isg3d_pkg::*;

	localparam int unsigned SITES = SIDE * SIDE * SIDE;
	localparam int unsigned PLANE = SIDE * SIDE;
	localparam int AW = $clog2(SITES);
	localparam logic [AW:0] SITES_X = (AW+1)'(SITES);

	logic [AW:0] ofs;
	logic [AW:0] site_x;
	logic [AW:0] up_sum;
	logic [AW:0] up_wrap;
	logic [AW:0] dn_wrap;
	logic        dec;

	always_comb begin
		unique case (sel) inside
			NB_XP, NB_XM: ofs = (AW+1)'(1);
			NB_YP, NB_YM: ofs = (AW+1)'(SIDE);
			NB_ZP, NB_ZM: ofs = (AW+1)'(PLANE);
			default:      ofs = '0;
		endcase
	end

	assign dec     = (sel == NB_XM) || (sel == NB_YM) || (sel == NB_ZM);
	assign site_x  = {1'b0, site};
	assign up_sum  = site_x + ofs;
	assign up_wrap = (up_sum >= SITES_X) ? (up_sum - SITES_X) : up_sum;
	assign dn_wrap = (site_x >= ofs) ? (site_x - ofs) : (site_x + SITES_X - ofs);
	assign addr    = dec ? dn_wrap[AW-1:0] : up_wrap[AW-1:0];
endmodule
`default_nettype wire

@@ hdl/isg3d_ctrl.sv @@
// item sequencer: lattice reads, disagreement count, flip decision, write-back
`default_nettype none
module isg3d_ctrl #(
	parameter int SIDE      = isg3d_pkg::SIDE_DEF,
	parameter int RAND_BITS = isg3d_pkg::RAND_BITS_DEF
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                in_valid,
	output logic                                     in_ready,
	input  wire logic                                op,
	input  wire logic [isg3d_pkg::SITE_W-1:0]        site,
	input  wire logic                                spin_in,
	input  wire logic [isg3d_pkg::THRESH_W-1:0]      random_word,
	input  wire isg3d_pkg::thresh_arr_t              thresh,
	input  wire logic                                res_take,
	output logic                                     res_vld,
	output isg3d_pkg::res_t                          res
);
	import isg3d_pkg::*;

	localparam int unsigned SITES = SIDE * SIDE * SIDE;
	localparam int AW = $clog2(SITES);
	localparam logic [AW-1:0] LAST_SITE = AW'(SITES - 1);
	localparam logic [THRESH_W-1:0] RAND_MASK =
		(RAND_BITS >= THRESH_W) ? '1 : THRESH_W'((64'd1 << RAND_BITS) - 64'd1);

	localparam logic [1:0] ST_CLEAR  = 2'd0;
	localparam logic [1:0] ST_IDLE   = 2'd1;
	localparam logic [1:0] ST_READ   = 2'd2;
	localparam logic [1:0] ST_DECIDE = 2'd3;

	logic [1:0]          state_q;
	logic [AW-1:0]       clr_q;
	nbr_sel_t            cnt_q;
	logic                op_q;
	logic [AW-1:0]       site_q;
	logic                spin_q;
	logic [THRESH_W-1:0] rnd_q;
	logic                inrange_q;
	logic                old_q;
	logic [DIS_W-1:0]    acc_q;
	logic [UP_W-1:0]     up_q;

	logic                in_xfer;
	logic                in_range;
	nbr_sel_t            sel;
	logic [AW-1:0]       nbr_addr;
	logic                mem_en;
	logic                mem_we;
	logic [AW-1:0]       mem_addr;
	logic                mem_wdata;
	logic                rdata;
	logic                me;
	logic [DIS_W-1:0]    dis;
	logic                flip;
	logic                new_spin;
	logic [UP_W-1:0]     up_next;
	logic                decide;

	assign in_ready = (state_q == ST_IDLE);
	assign in_xfer  = in_valid && in_ready;
	assign in_range = (32'(site) < SITES);
	assign sel      = (state_q == ST_READ) ? cnt_q : NB_SELF;
	assign decide   = (state_q == ST_DECIDE) && res_take;

	isg3d_nbr #(
		.SIDE (SIDE)
	) u_nbr (
		.site (site_q),
		.sel  (sel),
		.addr (nbr_addr)
	);

	isg3d_ram #(
		.WIDTH (1),
		.DEPTH (SITES)
	) u_lattice (
		.clk   (clk),
		.en    (mem_en),
		.we    (mem_we),
		.addr  (mem_addr),
		.wdata (mem_wdata),
		.rdata (rdata)
	);

	assign me       = (op_q == OP_UPDATE) ? old_q : spin_q;
	assign dis      = acc_q + DIS_W'(rdata ^ me);
	assign flip     = (op_q == OP_UPDATE) && (rnd_q < thresh[dis]);
	assign new_spin = (op_q == OP_UPDATE) ? (old_q ^ flip) : spin_q;

	always_comb begin
		up_next = up_q;
		if (inrange_q && (new_spin != old_q)) begin
			up_next = new_spin ? (up_q + UP_W'(1)) : (up_q - UP_W'(1));
		end
	end

	always_comb begin
		mem_en    = 1'b0;
		mem_we    = 1'b0;
		mem_addr  = nbr_addr;
		mem_wdata = new_spin;
		unique case (state_q)
			ST_CLEAR: begin
				mem_en    = 1'b1;
				mem_we    = 1'b1;
				mem_addr  = clr_q;
				mem_wdata = 1'b0;
			end
			ST_READ: begin
				mem_en = 1'b1;
			end
			ST_DECIDE: begin
				mem_en = decide && inrange_q;
				mem_we = 1'b1;
			end
			default: begin
				mem_en = 1'b0;
			end
		endcase
	end

	assign res_vld = decide;
	always_comb begin
		res.up_count       = up_next;
		res.flipped        = inrange_q && flip;
		res.disagree_count = inrange_q ? dis : '0;
		res.spin_out       = inrange_q && new_spin;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q   <= '0;
			cnt_q   <= NB_SELF;
			up_q    <= '0;
		end else begin
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == LAST_SITE) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					cnt_q <= NB_SELF;
					if (in_xfer) begin
						state_q <= in_range ? ST_READ : ST_DECIDE;
					end
				end
				ST_READ: begin
					cnt_q <= cnt_q + nbr_sel_t'(1);
					if (cnt_q == NB_ZM) begin
						state_q <= ST_DECIDE;
					end
				end
				ST_DECIDE: begin
					if (res_take) begin
						up_q    <= up_next;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			op_q      <= op;
			site_q    <= AW'(site);
			spin_q    <= spin_in;
			rnd_q     <= random_word & RAND_MASK;
			inrange_q <= in_range;
			old_q     <= 1'b0;
			acc_q     <= '0;
		end else if (state_q == ST_READ) begin
			// read data belongs to the slot issued in the cycle before
			if (cnt_q == NB_XP) begin
				old_q <= rdata;
			end else if (cnt_q != NB_SELF) begin
				acc_q <= acc_q + DIS_W'(rdata ^ me);
			end
		end
	end
endmodule
`default_nettype wire

@@ hdl/ising_3d_metropolis_update_top.sv @@
// Metropolis spin-flip update on a cubic Ising lattice of one-bit spins with helical
// periodic neighbours (+/-1, +/-SIDE, +/-SIDE*SIDE modulo SIDE**3). A tuser=0 transfer
// writes a spin, a tuser=1 transfer attempts a flip against the threshold chosen by the
// number of disagreeing neighbours; every input transfer gives one result transfer with
// the running up-spin count. No new transfer is taken until the last item's result is in
// the output register: the site and its six neighbours are read one per cycle from a
// single-port lattice ram, then a decide state, which waits while the output register is
// full and not taken, decides and writes back. A site beyond the lattice skips the reads
// and the write-back. After reset a clearing pass writes every site down, during which no
// input transfer is taken; threshold writes are taken at any time.
`default_nettype none
`include "ising_3d_metropolis_update_top_defines.svh"
module ising_3d_metropolis_update_top #(
	parameter int SIDE      = isg3d_pkg::SIDE_DEF,
	parameter int RAND_BITS = isg3d_pkg::RAND_BITS_DEF
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 s_axis_tvalid,
	output logic                                      s_axis_tready,
	// site[14:0], spin_in[15], random_word[46:16], zero[47]
	input  wire logic [47:0]                          s_axis_tdata,
	// op[0]
	input  wire logic                                 s_axis_tuser,
	output logic                                      m_axis_tvalid,
	input  wire logic                                 m_axis_tready,
	// flipped[0], disagree_count[3:1], spin_out[4], up_count[20:5], zero[23:21]
	output logic [23:0]                               m_axis_tdata,
	input  wire logic                                 cfg_wen,
	input  wire logic [isg3d_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire logic [isg3d_pkg::THRESH_W-1:0]       cfg_wdata
);
	import isg3d_pkg::*;

	localparam logic [CFG_IDX_W-1:0] LAST_IDX = CFG_IDX_W'(NUM_THRESH - 1);

	thresh_arr_t thresh_q;
	logic        out_vld_q;
	res_t        out_q;
	logic        res_take;
	logic        res_vld;
	res_t        res;

	assign res_take = !out_vld_q || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_THRESH; i++) begin
				thresh_q[i] <= (i < 3) ? '0 : '1;
			end
		end else if (cfg_wen && (cfg_index <= LAST_IDX)) begin
			thresh_q[cfg_index] <= cfg_wdata;
		end
	end

	isg3d_ctrl #(
		.SIDE      (SIDE),
		.RAND_BITS (RAND_BITS)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (s_axis_tvalid),
		.in_ready    (s_axis_tready),
		.op          (s_axis_tuser),
		.site        (s_axis_tdata[14:0]),
		.spin_in     (s_axis_tdata[15]),
		.random_word (s_axis_tdata[46:16]),
		.thresh      (thresh_q),
		.res_take    (res_take),
		.res_vld     (res_vld),
		.res         (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (res_take) begin
			out_vld_q <= res_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (res_vld) begin
			out_q <= res;
		end
	end

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata  = {3'b000, out_q.up_count, out_q.spin_out,
		out_q.disagree_count, out_q.flipped};

	`ISG3D_ASSERT_IMP(a_no_overwrite, res_vld, !out_vld_q || m_axis_tready)
	`ISG3D_ASSERT_NEXT(a_one_item, s_axis_tvalid && s_axis_tready, !s_axis_tready)
	`ISG3D_ASSERT_IMP(a_dis_range, res_vld, res.disagree_count <= 3'd6)
	`ISG3D_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready,
		m_axis_tvalid && $stable(m_axis_tdata))
endmodule
`default_nettype wire

@@ tb/ising_flip_checker.sv @@
`timescale 1ns / 1ps
// result checker for the metropolis block: mirrors lattice and thresholds, predicts and compares
module ising_flip_checker (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_axis_tvalid,
	input  logic                                 s_axis_tready,
	// site[14:0], spin_in[15], random_word[46:16], zero[47]
	input  logic [47:0]                          s_axis_tdata,
	// op[0]
	input  logic                                 s_axis_tuser,
	input  logic                                 m_axis_tvalid,
	input  logic                                 m_axis_tready,
	// flipped[0], disagree_count[3:1], spin_out[4], up_count[20:5], zero[23:21]
	input  logic [23:0]                          m_axis_tdata,
	input  logic                                 cfg_wen,
	input  logic [isg3d_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [isg3d_pkg::THRESH_W-1:0]       cfg_wdata,
	output int                                   fail_count,
	output int                                   pending
);
	import isg3d_pkg::*;

	localparam int LAT_SIDE   = SIDE_DEF;
	localparam int LAT_PLANE  = LAT_SIDE * LAT_SIDE;
	localparam int LAT_SITES  = LAT_PLANE * LAT_SIDE;
	localparam int SHOW_LIMIT = 10;

	bit            lattice [LAT_SITES];
	logic [UP_W-1:0] up_total;
	thresh_t       thr_regs [NUM_THRESH];
	res_t          expected_spin_results [$];
	res_t          want, got;
	int            result_idx;

	function automatic logic [DIS_W-1:0] count_unlike(input int unsigned s, input bit me);
		int unsigned off;
		logic [DIS_W-1:0] c;
		c = '0;
		for (int k = 0; k < 3; k++) begin
			off = (k == 0) ? 1 : (k == 1) ? LAT_SIDE : LAT_PLANE;
			c += DIS_W'(lattice[(s + off) % LAT_SITES] ^ me);
			c += DIS_W'(lattice[(s + LAT_SITES - off) % LAT_SITES] ^ me);
		end
		return c;
	endfunction

	function automatic void set_spin(input int unsigned s, input bit v);
		if (lattice[s] != v) begin
			lattice[s] = v;
			if (v)
				up_total++;
			else
				up_total--;
		end
	endfunction

	function automatic res_t predict_metropolis(input logic op, input int unsigned s,
			input bit spin_in, input thresh_t word);
		res_t r;
		bit me;
		r = '0;
		if (s < LAT_SITES) begin
			if (op == OP_WRITE) begin
				set_spin(s, spin_in);
				me = spin_in;
				r.disagree_count = count_unlike(s, me);
			end else begin
				me = lattice[s];
				r.disagree_count = count_unlike(s, me);
				if (word < thr_regs[r.disagree_count]) begin
					me = ~me;
					set_spin(s, me);
					r.flipped = 1'b1;
				end
			end
			r.spin_out = me;
		end
		r.up_count = up_total;
		return r;
	endfunction

	function automatic string show(input res_t r);
		return $sformatf("flipped=%0b disagree=%0d spin=%0b up=%0d",
			r.flipped, r.disagree_count, r.spin_out, r.up_count);
	endfunction

	function automatic void note_failure(input string msg);
		fail_count++;
		if (fail_count <= SHOW_LIMIT)
			$display("%s", msg);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < LAT_SITES; i++)
				lattice[i] = 1'b0;
			for (int k = 0; k < NUM_THRESH; k++)
				thr_regs[k] = (k < NUM_THRESH / 2) ? '0 : '1;
			up_total = '0;
			expected_spin_results.delete();
			fail_count = 0;
			pending = 0;
			result_idx = 0;
		end else begin
			if (cfg_wen && cfg_index < NUM_THRESH)
				thr_regs[cfg_index] = cfg_wdata;
			if (s_axis_tvalid && s_axis_tready)
				expected_spin_results.push_back(predict_metropolis(s_axis_tuser,
					s_axis_tdata[SITE_W-1:0], s_axis_tdata[SITE_W],
					s_axis_tdata[SITE_W+THRESH_W:SITE_W+1]));
			if (m_axis_tvalid && m_axis_tready) begin
				got = res_t'(m_axis_tdata[$bits(res_t)-1:0]);
				if (expected_spin_results.size() == 0) begin
					note_failure($sformatf("result %0d with nothing expected: got %s",
						result_idx, show(got)));
				end else begin
					want = expected_spin_results.pop_front();
					if (got.flipped !== want.flipped
							|| got.disagree_count !== want.disagree_count
							|| got.spin_out !== want.spin_out
							|| got.up_count !== want.up_count)
						note_failure($sformatf("result %0d: expected %s, got %s",
							result_idx, show(want), show(got)));
				end
				result_idx++;
			end
			pending = expected_spin_results.size();
		end
	end

endmodule

@@ tb/tb_ising_3d_metropolis_update_top.sv @@
`timescale 1ns / 1ps
// testbench top for the metropolis block: stimulus, ready pattern, threshold phases, verdict
module tb_ising_3d_metropolis_update_top;
	import isg3d_pkg::*;

	localparam int LAT_SIDE     = SIDE_DEF;
	localparam int LAT_PLANE    = LAT_SIDE * LAT_SIDE;
	localparam int LAT_SITES    = LAT_PLANE * LAT_SIDE;
	localparam int RANDOM_ITEMS = 1850;
	localparam int CLUSTER_LEN  = 40;
	localparam int SEED_WRITES  = 8;
	localparam int CYCLE_LIMIT  = 600000;
	localparam thresh_t THRESH_MAX = '1;

	localparam logic [SITE_W-1:0] S_ORIGIN = '0;
	localparam logic [SITE_W-1:0] S_XP  = SITE_W'(1);
	localparam logic [SITE_W-1:0] S_XM  = SITE_W'(LAT_SITES - 1);
	localparam logic [SITE_W-1:0] S_YP  = SITE_W'(LAT_SIDE);
	localparam logic [SITE_W-1:0] S_YM  = SITE_W'(LAT_SITES - LAT_SIDE);
	localparam logic [SITE_W-1:0] S_ZP  = SITE_W'(LAT_PLANE);
	localparam logic [SITE_W-1:0] S_ZM  = SITE_W'(LAT_SITES - LAT_PLANE);
	localparam logic [SITE_W-1:0] S_MID = SITE_W'(LAT_SITES / 2);

	typedef enum {PH_ALL_ACCEPT, PH_NONE_ACCEPT, PH_BOLTZMANN, PH_RANDOM,
		PH_EVEN_CLOSED, PH_ODD_CLOSED, PH_COUNT} thresh_phase_e;
	typedef enum {RDY_ALWAYS, RDY_COIN, RDY_SPARSE, RDY_EVERY4} ready_mode_e;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 s_axis_tvalid = 1'b0;
	logic                 s_axis_tready;
	logic [47:0]          s_axis_tdata = '0;
	logic                 s_axis_tuser = 1'b0;
	logic                 m_axis_tvalid;
	logic                 m_axis_tready = 1'b0;
	logic [23:0]          m_axis_tdata;
	logic                 cfg_wen = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	thresh_t              cfg_wdata = '0;

	int          fail_count, pending;
	thresh_t     thr_shadow [NUM_THRESH];
	int          burst_left = 0;
	bit          steady_feed = 1'b0;
	int          cycles = 0;
	ready_mode_e ready_mode = RDY_ALWAYS;
	int          ready_left = 0;
	int          ready_tick = 0;

	ising_3d_metropolis_update_top u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_wen       (cfg_wen),
		.cfg_index     (cfg_index),
		.cfg_wdata     (cfg_wdata)
	);

	ising_flip_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_wen       (cfg_wen),
		.cfg_index     (cfg_index),
		.cfg_wdata     (cfg_wdata),
		.fail_count    (fail_count),
		.pending       (pending)
	);

	always #2 clk = ~clk;

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	always @(negedge clk) begin
		if (ready_left == 0) begin
			ready_mode = ready_mode_e'($urandom_range(0, 3));
			ready_left = $urandom_range(20, 200);
		end
		ready_left--;
		ready_tick++;
		case (ready_mode)
			RDY_ALWAYS: m_axis_tready <= 1'b1;
			RDY_COIN:   m_axis_tready <= $urandom_range(0, 1);
			RDY_SPARSE: m_axis_tready <= ($urandom_range(0, 7) == 0);
			default:    m_axis_tready <= (ready_tick % 4 == 0);
		endcase
	end

	// called and returning at a falling edge
	task automatic send_item(input logic op, input logic [SITE_W-1:0] site,
			input logic spin, input thresh_t word);
		int gap;
		if (burst_left == 0) begin
			gap = steady_feed ? 0 : $urandom_range(0, 12);
			burst_left = $urandom_range(1, 16);
			if (gap > 0) begin
				s_axis_tvalid = 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		burst_left--;
		s_axis_tvalid = 1'b1;
		s_axis_tuser = op;
		s_axis_tdata = {1'b0, word, spin, site};
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic wait_drained();
		s_axis_tvalid = 1'b0;
		burst_left = 0;
		while (pending != 0)
			@(negedge clk);
	endtask

	task automatic write_thresh(input int idx, input thresh_t val);
		cfg_wen = 1'b1;
		cfg_index = CFG_IDX_W'(idx);
		cfg_wdata = val;
		thr_shadow[idx] = val;
		@(negedge clk);
		cfg_wen = 1'b0;
	endtask

	task automatic load_phase(input thresh_phase_e phase);
		thresh_t val;
		for (int k = 0; k < NUM_THRESH; k++) begin
			case (phase)
				PH_ALL_ACCEPT:  val = THRESH_MAX;
				PH_NONE_ACCEPT: val = '0;
				PH_BOLTZMANN:   val = (k >= NUM_THRESH / 2) ? THRESH_MAX :
					thresh_t'($urandom >> (7 - 2 * k));
				PH_RANDOM:      val = thresh_t'($urandom);
				PH_EVEN_CLOSED: val = k[0] ? THRESH_MAX : '0;
				default:        val = k[0] ? '0 : THRESH_MAX;
			endcase
			write_thresh(k, val);
		end
	endtask

	// words near the live thresholds hit the strict-compare boundary
	function automatic thresh_t pick_word();
		thresh_t t;
		t = thr_shadow[$urandom_range(0, NUM_THRESH - 1)];
		case ($urandom_range(0, 9))
			0:       return '0;
			1:       return THRESH_MAX;
			2, 3:    return t;
			4:       return t - 1'b1;
			5:       return t + 1'b1;
			default: return thresh_t'($urandom);
		endcase
	endfunction

	function automatic logic [SITE_W-1:0] cluster_site(input int unsigned base);
		return SITE_W'((base + $urandom_range(0, 3) + LAT_SIDE * $urandom_range(0, 3)
			+ LAT_PLANE * $urandom_range(0, 3)) % LAT_SITES);
	endfunction

	initial begin : stimulus
		int unsigned base;
		logic [SITE_W-1:0] site;
		logic op;
		int sent;
		int phase_end;
		for (int k = 0; k < NUM_THRESH; k++)
			thr_shadow[k] = (k < NUM_THRESH / 2) ? '0 : THRESH_MAX;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;

		// directed: reset thresholds, origin and its wrapped neighbours
		send_item(OP_UPDATE, S_ORIGIN, 1'b0, '0);
		send_item(OP_WRITE,  S_ORIGIN, 1'b1, thresh_t'(31'h5a5a5a5a));
		send_item(OP_UPDATE, S_ORIGIN, 1'b0, THRESH_MAX);
		send_item(OP_UPDATE, S_ORIGIN, 1'b1, THRESH_MAX - 1'b1);
		send_item(OP_WRITE,  S_XP, 1'b1, '0);
		send_item(OP_WRITE,  S_XM, 1'b1, THRESH_MAX);
		send_item(OP_WRITE,  S_YP, 1'b1, '0);
		send_item(OP_WRITE,  S_YM, 1'b1, '0);
		send_item(OP_WRITE,  S_ZP, 1'b1, '0);
		send_item(OP_WRITE,  S_ZM, 1'b1, '0);
		send_item(OP_UPDATE, S_ORIGIN, 1'b0, '0);
		send_item(OP_UPDATE, S_ORIGIN, 1'b0, THRESH_MAX);
		send_item(OP_WRITE,  S_ORIGIN, 1'b1, '0);
		send_item(OP_WRITE,  S_XM, 1'b0, '0);
		send_item(OP_WRITE,  S_ZM, 1'b0, '0);
		send_item(OP_UPDATE, S_ORIGIN, 1'b0, '0);
		send_item(OP_UPDATE, S_XM, 1'b1, '0);
		send_item(OP_WRITE,  S_MID, 1'b1, THRESH_MAX);
		send_item(OP_UPDATE, S_MID, 1'b0, THRESH_MAX - 1'b1);

		sent = 0;
		for (int p = 0; p < PH_COUNT; p++) begin
			wait_drained();
			load_phase(thresh_phase_e'(p));
			phase_end = (p + 1) * RANDOM_ITEMS / PH_COUNT;
			while (sent < phase_end) begin
				if ($urandom_range(0, 3) == 0)
					base = LAT_SITES - 2 - LAT_PLANE;
				else
					base = $urandom_range(0, LAT_SITES - 1);
				steady_feed = ($urandom_range(0, 3) == 0);
				if ($urandom_range(0, 7) == 0)
					wait_drained();
				// seed a small block with random spins, then mostly updates inside it
				for (int j = 0; j < CLUSTER_LEN; j++) begin
					if ($urandom_range(0, 9) == 0)
						site = SITE_W'($urandom_range(0, LAT_SITES - 1));
					else
						site = cluster_site(base);
					if (j < SEED_WRITES)
						op = OP_WRITE;
					else
						op = ($urandom_range(0, 3) == 0) ? OP_WRITE : OP_UPDATE;
					send_item(op, site, $urandom_range(0, 1), pick_word());
					sent++;
				end
			end
		end

		wait_drained();
		repeat (20) @(negedge clk);
		if (fail_count == 0 && pending == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
